[hw/rtl/hphc_pkg.sv]
package hphc_pkg;

   localparam int TEMP_WIDTH = 16;

   // divider geometry: widest dividend is |gain_d * de * 1000| < 2^43
   localparam int DIV_N     = 43;
   localparam int DIV_D     = 16;
   localparam int DIV_CNT_W = 6;

   localparam logic [DIV_N-1:0]  ICLAMP_NUM = 43'd6553600000;
   localparam logic [DIV_D-1:0]  MS_PER_S   = 16'd1000;
   localparam logic [7:0]        FULL_DUTY  = 8'd255;
   localparam logic [15:0]       DT_MAX     = 16'hFFFF;
   localparam logic signed [39:0] IACC_MAX  = 40'sd6553600000;

   // x / 1000 = ((x >> 3) * I_RECIP) >> I_RECIP_SH, exact for x < 2^33
   localparam logic [30:0] I_RECIP    = 31'd1099511628;
   localparam int          I_RECIP_SH = 37;

   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_SET    = 2'd1;
   localparam logic [1:0] FUNC_OFF    = 2'd2;
   localparam logic [1:0] FUNC_RSVD   = 2'd3;

   localparam logic MODE_PID  = 1'b0;
   localparam logic MODE_HYST = 1'b1;

   typedef enum logic [2:0] {
      CSR_MODE = 3'd0,
      CSR_GP   = 3'd1,
      CSR_GI   = 3'd2,
      CSR_GD   = 3'd3,
      CSR_MIN  = 3'd4,
      CSR_THR  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [TEMP_WIDTH-1:0] measured_temp;
      logic signed [TEMP_WIDTH-1:0] setpoint_temp;
      logic [31:0]                  now_ms;
      logic                         heat_request;
   } req_type;

   typedef struct packed {
      logic       heat_on;
      logic [7:0] pwm_duty;
   } rsp_type;

   typedef struct packed {
      logic        ctrl_mode;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] min_interval_ms;
      logic [7:0]  on_threshold;
   } cfg_type;

   typedef enum logic [1:0] {
      DIV_LIM = 2'd0,
      DIV_DER = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACC,
      ST_LIM_WAIT,
      ST_IMUL_LO,
      ST_IMUL_HI,
      ST_I_RLO,
      ST_I_RHI,
      ST_I_TAKE,
      ST_D_START,
      ST_D_WAIT,
      ST_SUM,
      ST_DUTY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        simple;
      logic        mul;
      logic        acc;
      logic        div_start;
      div_sel_type div_sel;
      logic        clamp;
      logic        imul_lo;
      logic        imul_hi;
      logic        rmul_lo;
      logic        rmul_hi;
      logic        i_take;
      logic        d_take;
      logic        d_clear;
      logic        sum;
      logic        duty;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic pid_go;
      logic gi_zero;
      logic dt_zero;
      logic div_busy;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

[hw/rtl/hphc_div.sv]
module hphc_div
   import hphc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_N-1:0] dividend,
   input  logic [DIV_D-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_N-1:0] quotient,
   output logic             rem_nz
);

   logic [DIV_N-1:0]     quo_ff, quo_in;
   logic [DIV_D-1:0]     rem_ff, rem_in;
   logic [DIV_D-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D:0]       rem_sh;
   logic [DIV_D+1:0]     diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_N-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle
         if (!diff[DIV_D+1]) begin
            rem_in = diff[DIV_D-1:0];
            quo_in = {quo_ff[DIV_N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_D-1:0];
            quo_in = {quo_ff[DIV_N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = (rem_ff != '0);

endmodule

[hw/rtl/hphc_dp.sv]
module hphc_dp
   import hphc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   req_type            item_ff, item_in;
   logic signed [39:0] ia_ff, ia_in;
   logic signed [16:0] pe_ff, pe_in;
   logic               first_ff, first_in;
   logic [31:0]        last_ff, last_in;
   logic               heat_ff, heat_in;
   logic [7:0]         duty_ff, duty_in;

   logic signed [16:0] e_ff;
   logic [15:0]        dt_ff;
   logic signed [33:0] p16_ff, ep_ff;
   logic signed [34:0] dd_ff, acc_ff;
   logic signed [44:0] dd1000_ff;
   logic [32:0]        prod_lo_ff;
   logic [DIV_N-1:0]   prod_ff;
   logic [45:0]        rlo_ff;
   logic [23:0]        rq_ff;
   logic signed [24:0] i16_ff, i16_in;
   logic signed [44:0] d16_ff, d16_in;
   logic signed [45:0] sum_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [31:0]        elapsed;
   logic signed [16:0] e_w;
   logic [15:0]        dt_w;
   logic signed [17:0] de_w;
   logic signed [33:0] p16_w, ep_w;
   logic signed [34:0] dd_w, acc_w, lim35, accc;
   logic signed [44:0] dd_x, dd1000_w;
   logic [44:0]        dd_abs;
   logic [34:0]        iam;
   logic [31:0]        prod_hi_w;
   logic [48:0]        prod_full;
   logic [45:0]        rhi_w;
   logic [60:0]        rsum_w;
   logic [33:0]        i_back;
   logic               i_rem_nz;
   logic [24:0]        qi_adj;
   logic [43:0]        qd_adj;
   logic [7:0]         duty_w;
   logic               should;

   logic             div_start, div_busy, div_done, div_rem_nz;
   logic [DIV_N-1:0] div_dividend, div_quot;
   logic [DIV_D-1:0] div_divisor;

   always_comb begin
      elapsed = item_ff.now_ms - last_ff;
      e_w     = $signed({item_ff.setpoint_temp[TEMP_WIDTH-1], item_ff.setpoint_temp})
              - $signed({item_ff.measured_temp[TEMP_WIDTH-1], item_ff.measured_temp});
      dt_w    = (elapsed[31:16] != '0) ? DT_MAX : elapsed[15:0];
      de_w    = e_w - pe_ff;
      p16_w   = $signed({1'b0, cfg.gain_p}) * e_w;
      ep_w    = $signed({1'b0, dt_w}) * e_w;
      dd_w    = $signed({1'b0, cfg.gain_d}) * de_w;
      acc_w   = $signed(ia_ff[34:0]) + ep_ff;
      dd_x    = dd_ff;
      // x * 1000 = x*1024 - x*16 - x*8
      dd1000_w = (dd_x <<< 10) - (dd_x <<< 4) - (dd_x <<< 3);
      dd_abs   = dd1000_ff[44] ? 45'(-dd1000_ff) : dd1000_ff;
      lim35    = $signed({2'b00, div_quot[32:0]});
      if (acc_ff > lim35)       accc = lim35;
      else if (acc_ff < -lim35) accc = -lim35;
      else                      accc = acc_ff;
      iam       = ia_ff[39] ? 35'(-$signed(ia_ff[34:0])) : ia_ff[34:0];
      prod_hi_w = cfg.gain_i * iam[32:17];
      prod_full = {16'b0, prod_lo_ff} + {prod_hi_w, 17'b0};
      // scale the integral product by 1/1000, upper half of the split multiply
      rhi_w     = prod_ff[32:18] * I_RECIP;
      rsum_w    = {15'b0, rlo_ff} + {rhi_w, 15'b0};
      i_back    = {10'b0, rq_ff} * {18'b0, MS_PER_S};
      i_rem_nz  = (i_back != prod_ff[33:0]);
      qi_adj    = {1'b0, rq_ff} + 25'(i_rem_nz);
      qd_adj    = {1'b0, div_quot} + 44'(div_rem_nz);
      if (sum_ff[45])                duty_w = '0;
      else if (sum_ff[44:24] != '0)  duty_w = FULL_DUTY;
      else                           duty_w = sum_ff[23:16];
      should = item_ff.measured_temp < item_ff.setpoint_temp;
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_LIM: begin
            div_dividend = ICLAMP_NUM;
            div_divisor  = cfg.gain_i;
         end
         DIV_DER: begin
            div_dividend = dd_abs[DIV_N-1:0];
            div_divisor  = dt_ff;
         end
         default: begin
            div_dividend = ICLAMP_NUM;
            div_divisor  = cfg.gain_i;
         end
      endcase
      div_start = cmd.div_start;
   end

   always_comb begin
      item_in      = item_ff;
      ia_in        = ia_ff;
      pe_in        = pe_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      heat_in      = heat_ff;
      duty_in      = duty_ff;
      i16_in       = i16_ff;
      d16_in       = d16_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) item_in = req_data;

      if (cmd.simple) begin
         case (item_ff.func)
            FUNC_UPDATE: begin
               if (cfg.ctrl_mode == MODE_HYST) begin
                  if (should != heat_ff) begin
                     heat_in = should;
                     duty_in = should ? FULL_DUTY : '0;
                  end
               end else begin
                  // first run or short interval: only restart the timebase
                  last_in  = item_ff.now_ms;
                  first_in = 1'b0;
               end
            end
            FUNC_SET: begin
               heat_in = item_ff.heat_request;
               if (!item_ff.heat_request)           duty_in = '0;
               else if (cfg.ctrl_mode == MODE_HYST) duty_in = FULL_DUTY;
            end
            FUNC_OFF: begin
               heat_in  = 1'b0;
               duty_in  = '0;
               ia_in    = '0;
               pe_in    = '0;
               first_in = 1'b1;
               last_in  = '0;
            end
            default: ;
         endcase
      end

      if (cmd.acc && cfg.gain_i == '0) begin
         ia_in  = '0;
         i16_in = '0;
      end
      if (cmd.clamp)  ia_in  = {{5{accc[34]}}, accc};
      if (cmd.i_take) i16_in = ia_ff[39] ? -$signed(qi_adj) : $signed(qi_adj);
      if (cmd.d_take)
         d16_in = dd1000_ff[44] ? -$signed({1'b0, qd_adj}) : $signed({1'b0, qd_adj});
      if (cmd.d_clear) d16_in = '0;
      if (cmd.duty) begin
         duty_in = duty_w;
         heat_in = duty_w > cfg.on_threshold;
         pe_in   = e_ff;
         last_in = item_ff.now_ms;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{heat_on: heat_ff, pwm_duty: duty_ff};
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      i16_ff  <= i16_in;
      d16_ff  <= d16_in;
      rsp_ff  <= rsp_in;
      if (cmd.mul) begin
         e_ff   <= e_w;
         dt_ff  <= dt_w;
         p16_ff <= p16_w;
         ep_ff  <= ep_w;
         dd_ff  <= dd_w;
      end
      if (cmd.acc) begin
         acc_ff    <= acc_w;
         dd1000_ff <= dd1000_w;
      end
      if (cmd.imul_lo) prod_lo_ff <= cfg.gain_i * iam[16:0];
      if (cmd.imul_hi) prod_ff    <= prod_full[DIV_N-1:0];
      if (cmd.rmul_lo) rlo_ff     <= prod_ff[17:3] * I_RECIP;
      if (cmd.rmul_hi) rq_ff      <= rsum_w[I_RECIP_SH+23:I_RECIP_SH];
      if (cmd.sum)     sum_ff     <= p16_ff + i16_ff + d16_ff;
      if (reset) begin
         ia_ff        <= '0;
         pe_ff        <= '0;
         first_ff     <= 1'b1;
         last_ff      <= '0;
         heat_ff      <= 1'b0;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ia_ff        <= ia_in;
         pe_ff        <= pe_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         heat_ff      <= heat_in;
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   hphc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot),
      .rem_nz   (div_rem_nz)
   );

   always_comb begin
      sts.pid_go   = (item_ff.func == FUNC_UPDATE) && (cfg.ctrl_mode == MODE_PID)
                  && !first_ff && (elapsed >= {16'b0, cfg.min_interval_ms});
      sts.gi_zero  = (cfg.gain_i == '0);
      sts.dt_zero  = (dt_ff == '0);
      sts.div_busy = div_busy;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_iacc_bound: assert property (@(posedge clock) disable iff (reset)
      (ia_ff <= IACC_MAX) && (ia_ff >= -IACC_MAX))
      else $error("integral accumulator outside clamp range");

endmodule

[hw/rtl/hphc_ctrl.sv]
module hphc_ctrl
   import hphc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.pid_go) begin
               cmd.mul  = 1'b1;
               state_in = ST_ACC;
            end else begin
               cmd.simple = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (sts.gi_zero) begin
               state_in = ST_D_START;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_LIM;
               state_in      = ST_LIM_WAIT;
            end
         end
         ST_LIM_WAIT: begin
            cmd.div_sel = DIV_LIM;
            if (sts.div_done) begin
               cmd.clamp = 1'b1;
               state_in  = ST_IMUL_LO;
            end
         end
         ST_IMUL_LO: begin
            cmd.imul_lo = 1'b1;
            state_in    = ST_IMUL_HI;
         end
         ST_IMUL_HI: begin
            cmd.imul_hi = 1'b1;
            state_in    = ST_I_RLO;
         end
         ST_I_RLO: begin
            cmd.rmul_lo = 1'b1;
            state_in    = ST_I_RHI;
         end
         ST_I_RHI: begin
            cmd.rmul_hi = 1'b1;
            state_in    = ST_I_TAKE;
         end
         ST_I_TAKE: begin
            cmd.i_take = 1'b1;
            state_in   = ST_D_START;
         end
         ST_D_START: begin
            if (sts.dt_zero) begin
               cmd.d_clear = 1'b1;
               state_in    = ST_SUM;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DER;
               state_in      = ST_D_WAIT;
            end
         end
         ST_D_WAIT: begin
            cmd.div_sel = DIV_DER;
            if (sts.div_done) begin
               cmd.d_take = 1'b1;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register frees up
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider restarted while busy");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_LIM_WAIT || state_ff == ST_D_WAIT))
      else $error("divider result arrived outside a wait state");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted transaction not decoded");

endmodule

[hw/rtl/heater_pid_hysteresis_controller_top.sv]
// channel  | ports                          | direction
// ---------+--------------------------------+----------
// request  | req_valid req_stall req_data   | in
// response | rsp_valid rsp_stall rsp_data   | out
// config   | psel penable pwrite paddr ...  | in/out
//
// One transaction at a time. Direct commands, hysteresis updates and skipped
// PID updates go from decode straight to the done state; a full PID update
// makes up to two passes of the shared 43-step radix-2 divider (clamp limit,
// derivative over dt); the integral scaling is a reciprocal multiply. Reset is
// synchronous and restores the register defaults and the cleared PID state.
// A new request is taken while the previous result still waits under rsp_stall.
module heater_pid_hysteresis_controller_top
   import hphc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_idx;
   logic          csr_wr;
   cmd_type       cmd;
   sts_type       sts;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_idx)
         CSR_MODE: begin
            prdata = {31'b0, cfg_ff.ctrl_mode};
            if (csr_wr) cfg_in.ctrl_mode = pwdata[0];
         end
         CSR_GP: begin
            prdata = {16'b0, cfg_ff.gain_p};
            if (csr_wr) cfg_in.gain_p = pwdata[15:0];
         end
         CSR_GI: begin
            prdata = {16'b0, cfg_ff.gain_i};
            if (csr_wr) cfg_in.gain_i = pwdata[15:0];
         end
         CSR_GD: begin
            prdata = {16'b0, cfg_ff.gain_d};
            if (csr_wr) cfg_in.gain_d = pwdata[15:0];
         end
         CSR_MIN: begin
            prdata = {16'b0, cfg_ff.min_interval_ms};
            if (csr_wr) cfg_in.min_interval_ms = pwdata[15:0];
         end
         CSR_THR: begin
            prdata = {24'b0, cfg_ff.on_threshold};
            if (csr_wr) cfg_in.on_threshold = pwdata[7:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ctrl_mode: MODE_PID, gain_p: 16'd512, gain_i: 16'd26,
                     gain_d: 16'd256, min_interval_ms: 16'd1000, on_threshold: 8'd25};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hphc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hphc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
